FILE: src/fbp_pkg.sv
// ----------------------------------------------------------------------------
// fbp_pkg
// Shared types, widths and helpers for the fixed block pool free list.
// ----------------------------------------------------------------------------
package fbp_pkg;

    localparam int POOL_DEPTH = 256;
    localparam int SLOT_W     = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int LINK_W     = SLOT_W + 1;
    localparam int STEP_W     = (SLOT_W > 1) ? $clog2(SLOT_W) : 1;

    localparam int ADDR_W     = 32;
    localparam int SIZE_W     = 16;
    localparam int ALIGN_W    = 13;
    localparam int EALIGN_W   = 14;
    localparam int STRIDE_W   = 17;
    localparam int CNT_W      = 9;
    localparam int STAT_W     = 3;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_W      = 32;
    localparam int SHIFT_W    = 4;

    localparam int MIN_SIZE         = 8;
    localparam int SIZE_RESET       = 8;
    localparam int ALIGN_RESET      = 8;
    localparam int SLOT_COUNT_RESET = 256;
    localparam int RESET_USED       = (POOL_DEPTH < SLOT_COUNT_RESET) ? POOL_DEPTH
                                                                      : SLOT_COUNT_RESET;
    localparam int FREE_MAX         = 511;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_RESET   = 2'd2,
        OP_NONE    = 2'd3
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_OOM      = 3'd1,
        STAT_SIZE     = 3'd2,
        STAT_ALIGN    = 3'd3,
        STAT_BOUNDS   = 3'd4,
        STAT_MISALIGN = 3'd5
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE  = 2'd0,
        CFG_SIZE  = 2'd1,
        CFG_ALIGN = 2'd2,
        CFG_COUNT = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_MUL,
        S_ADDF,
        S_TAKE,
        S_OFF,
        S_CHK,
        S_DIV,
        S_FIN,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        U_HOLD,
        U_LOAD,
        U_ADD,
        U_SUB,
        U_MUL,
        U_DIV
    } t_unit_op;

    typedef struct packed {
        t_unit_op            op;
        logic [STEP_W-1:0]   shift;
        logic                mbit;
    } t_unit_ctl;

    // log2 of the effective alignment: next power of two at or above the
    // request, never below 8 and never above 8192
    function automatic logic [SHIFT_W-1:0] align_shift(input logic [ALIGN_W-1:0] align);
        logic [SHIFT_W-1:0] sh;
        sh = SHIFT_W'(13);
        for (int k = 12; k >= 3; k--) begin
            if ({1'b0, align} <= (EALIGN_W'(1) << k)) begin
                sh = SHIFT_W'(k);
            end
        end
        return sh;
    endfunction

endpackage

FILE: src/fixed_block_pool_free_list.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_free_list
// Fixed-size block pool allocator: LIFO free list of slots in a link memory.
// ----------------------------------------------------------------------------
// Usage:
//   Config port: i_cfg_we writes i_cfg_data into register i_cfg_index
//   (0 base address, 1 object size, 2 alignment, 3 slot count). Write only
//   while the block is idle; derived stride and first-slot address settle
//   in the cycle after the write.
//   Input channel (i_in_valid / o_in_stall) takes one command word: allocate,
//   release or pool reset. Output channel (o_out_valid / i_out_stall) returns
//   one result word per command: slot address, status, free count.
//   Commands are handled one at a time. A shared accumulator runs a shift-add
//   multiply (8 steps) and, for a release, a restoring divide (8 steps).
//   Allocate: decode, multiply, add, take. Release: decode, multiply,
//   offset, check, divide, finish. Null release, reset, unused opcode and
//   decode errors stop at decode; input opens in the cycle after the result
//   is registered. A finished result waits in the output register while the
//   receiver stalls; a new command is accepted meanwhile, but its result
//   holds until the register frees.
//   Reset (synchronous, i_rst_n low) restores the config registers and
//   rebuilds the free list in slot order; a pool reset command does the
//   same with the current slot count.
// ----------------------------------------------------------------------------
module fixed_block_pool_free_list import fbp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [OP_W-1:0]      i_opcode,
    input  logic [ADDR_W-1:0]    i_address,
    input  logic [SIZE_W-1:0]    i_request_size,
    input  logic [ALIGN_W-1:0]   i_request_align,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [ADDR_W-1:0]    o_slot_address,
    output logic [STAT_W-1:0]    o_status,
    output logic [CNT_W-1:0]     o_free_slots
);

    // config registers
    logic [ADDR_W-1:0]   r_base;
    logic [SIZE_W-1:0]   r_osize;
    logic [ALIGN_W-1:0]  r_oalign;
    logic [CNT_W-1:0]    r_scount;

    // derived geometry
    logic [SIZE_W-1:0]   r_eff_size;
    logic [EALIGN_W-1:0] r_eff_align;
    logic [STRIDE_W-1:0] r_stride;
    logic [ADDR_W-1:0]   r_first;
    logic [CNT_W-1:0]    r_used;
    logic [SIZE_W-1:0]   eff_size_c;
    logic [EALIGN_W-1:0] eff_align_c;
    logic [EALIGN_W-1:0] amask;
    logic [CNT_W-1:0]    used_c;

    // list state
    logic [SLOT_W-1:0]     r_head;
    logic                  r_head_valid;
    logic [CNT_W-1:0]      r_free;
    logic [CNT_W-1:0]      r_build_n;
    logic [POOL_DEPTH-1:0] r_wr_flag;

    // sequencer
    t_state              r_state;
    t_state              n_state;
    logic [STEP_W-1:0]   r_k;
    logic [STEP_W-1:0]   n_k;
    t_opcode             r_op;
    logic [ADDR_W-1:0]   r_addr;
    logic [SIZE_W-1:0]   r_rsize;
    logic [ALIGN_W-1:0]  r_ralign;
    logic [ADDR_W-1:0]   r_limit;
    logic [ADDR_W-1:0]   r_res_addr;
    logic [ADDR_W-1:0]   n_res_addr;
    t_status             r_res_status;
    t_status             n_res_status;
    logic [SLOT_W-1:0]   mult;

    logic                commit_alloc;
    logic                push;
    logic                rebuild;
    logic                load_out;

    // output register
    logic                r_out_valid;
    logic [ADDR_W-1:0]   r_out_addr;
    t_status             r_out_status;
    logic [CNT_W-1:0]    r_out_free;

    // shared unit and link memory
    t_unit_ctl           ctl;
    logic [ADDR_W-1:0]   opa;
    logic [ADDR_W-1:0]   opb;
    logic [ADDR_W-1:0]   acc;
    logic [SLOT_W-1:0]   quot;
    logic                ram_re;
    logic                ram_we;
    logic [LINK_W-1:0]   ram_rdata;
    logic [SLOT_W-1:0]   next_link;
    logic                next_valid;

    fbp_step_unit u_step (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_opa  (opa),
        .i_opb  (opb),
        .o_acc  (acc),
        .o_quot (quot)
    );

    fbp_ram #(
        .WIDTH (LINK_W),
        .DEPTH (POOL_DEPTH)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (quot),
        .i_wdata ({r_head_valid, r_head}),
        .i_re    (ram_re),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    // geometry from the config registers
    assign eff_size_c  = (r_osize < SIZE_W'(MIN_SIZE)) ? SIZE_W'(MIN_SIZE) : r_osize;
    assign eff_align_c = EALIGN_W'(1) << align_shift(r_oalign);
    assign amask       = eff_align_c - EALIGN_W'(1);
    assign used_c      = ({{(32-CNT_W){1'b0}}, r_scount} > 32'(POOL_DEPTH))
                         ? CNT_W'(POOL_DEPTH) : r_scount;

    always_ff @(posedge i_clk) begin
        r_eff_size  <= eff_size_c;
        r_eff_align <= eff_align_c;
        r_stride    <= (STRIDE_W'(eff_size_c) + STRIDE_W'(amask)) & ~STRIDE_W'(amask);
        r_first     <= (r_base + ADDR_W'(amask)) & ~ADDR_W'(amask);
        r_used      <= used_c;
    end

    // an entry not written since the last rebuild still holds its chain link
    assign next_link  = r_wr_flag[r_head] ? ram_rdata[SLOT_W-1:0] : r_head + SLOT_W'(1);
    assign next_valid = r_wr_flag[r_head] ? ram_rdata[SLOT_W]
                        : ((CNT_W'(r_head) + CNT_W'(1)) < r_build_n);

    assign mult = (r_op == OP_ALLOC) ? r_head : SLOT_W'(r_used - CNT_W'(1));

    always_comb begin
        n_state      = r_state;
        n_k          = r_k;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        ctl          = '{op: U_HOLD, shift: r_k, mbit: 1'b0};
        opa          = '0;
        opb          = '0;
        ram_re       = 1'b0;
        ram_we       = 1'b0;
        commit_alloc = 1'b0;
        push         = 1'b0;
        rebuild      = 1'b0;
        load_out     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_res_addr   = '0;
                n_res_status = STAT_OK;
                n_k          = '0;
                ctl.op       = U_LOAD;
                n_state      = S_DONE;
                unique case (r_op)
                    OP_ALLOC: begin
                        if (r_rsize > r_eff_size) begin
                            n_res_status = STAT_SIZE;
                        end else if ({1'b0, r_ralign} > r_eff_align) begin
                            n_res_status = STAT_ALIGN;
                        end else if (!r_head_valid) begin
                            n_res_status = STAT_OOM;
                        end else begin
                            ram_re  = 1'b1;
                            n_state = S_MUL;
                        end
                    end
                    OP_RELEASE: begin
                        if (r_addr == '0) begin
                            n_res_status = STAT_OK;
                        end else if (r_used == '0) begin
                            n_res_status = STAT_BOUNDS;
                        end else begin
                            n_state = S_MUL;
                        end
                    end
                    OP_RESET: begin
                        rebuild = 1'b1;
                    end
                    OP_NONE: begin
                    end
                endcase
            end
            S_MUL: begin
                // slot index (allocate) or last slot index (release) times stride
                ctl.op   = U_MUL;
                ctl.mbit = mult[r_k];
                opb      = ADDR_W'(r_stride);
                n_k      = r_k + STEP_W'(1);
                if (r_k == STEP_W'(SLOT_W - 1)) begin
                    n_state = (r_op == OP_ALLOC) ? S_ADDF : S_OFF;
                end
            end
            S_ADDF: begin
                ctl.op       = U_ADD;
                opb          = r_first;
                commit_alloc = 1'b1;
                n_state      = S_TAKE;
            end
            S_TAKE: begin
                n_res_addr = acc;
                n_state    = S_DONE;
            end
            S_OFF: begin
                ctl.op  = U_SUB;
                opa     = r_addr;
                opb     = r_first;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (acc > r_limit) begin
                    n_res_status = STAT_BOUNDS;
                    n_state      = S_DONE;
                end else begin
                    n_k     = STEP_W'(SLOT_W - 1);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                ctl.op = U_DIV;
                opb    = ADDR_W'(r_stride);
                n_k    = r_k - STEP_W'(1);
                if (r_k == '0) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (acc != '0) begin
                    n_res_status = STAT_MISALIGN;
                end else begin
                    push   = 1'b1;
                    ram_we = 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_k          <= '0;
            r_base       <= '0;
            r_osize      <= SIZE_W'(SIZE_RESET);
            r_oalign     <= ALIGN_W'(ALIGN_RESET);
            r_scount     <= CNT_W'(SLOT_COUNT_RESET);
            r_head       <= '0;
            r_head_valid <= (RESET_USED != 0);
            r_free       <= CNT_W'(RESET_USED);
            r_build_n    <= CNT_W'(RESET_USED);
            r_wr_flag    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_BASE:  r_base   <= i_cfg_data[ADDR_W-1:0];
                    CFG_SIZE:  r_osize  <= i_cfg_data[SIZE_W-1:0];
                    CFG_ALIGN: r_oalign <= i_cfg_data[ALIGN_W-1:0];
                    CFG_COUNT: r_scount <= i_cfg_data[CNT_W-1:0];
                endcase
            end
            priority if (rebuild) begin
                r_head       <= '0;
                r_head_valid <= (r_used != '0);
                r_free       <= r_used;
                r_build_n    <= r_used;
                r_wr_flag    <= '0;
            end else if (commit_alloc) begin
                r_head       <= next_link;
                r_head_valid <= next_valid;
                if (r_free != '0) begin
                    r_free <= r_free - CNT_W'(1);
                end
            end else if (push) begin
                r_head          <= quot;
                r_head_valid    <= 1'b1;
                r_wr_flag[quot] <= 1'b1;
                if (r_free != CNT_W'(FREE_MAX)) begin
                    r_free <= r_free + CNT_W'(1);
                end
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_op     <= t_opcode'(i_opcode);
            r_addr   <= i_address;
            r_rsize  <= i_request_size;
            r_ralign <= i_request_align;
        end
        if (r_state == S_OFF) begin
            r_limit <= acc;
        end
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
        if (load_out) begin
            r_out_addr   <= r_res_addr;
            r_out_status <= r_res_status;
            r_out_free   <= r_free;
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_slot_address = r_out_addr;
    assign o_status       = r_out_status;
    assign o_free_slots   = r_out_free;

    a_err_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != STAT_OK)) |-> (o_slot_address == '0))
        else $error("error result carries a slot address");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second word taken while a command is in flight");

    a_push_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> (r_head_valid && (r_head == $past(quot))))
        else $error("released slot did not become the list head");

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> ((r_free == $past(r_free) + CNT_W'(1)) ||
                  ($past(r_free) == CNT_W'(FREE_MAX))))
        else $error("free count not advanced on release");

    a_alloc_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit_alloc |=> ((r_free == $past(r_free) - CNT_W'(1)) ||
                          ($past(r_free) == '0)))
        else $error("free count not dropped on allocate");

endmodule

FILE: src/fbp_ram.sv
// ----------------------------------------------------------------------------
// fbp_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module fbp_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/fbp_step_unit.sv
// ----------------------------------------------------------------------------
// fbp_step_unit
// Shared accumulator with one adder: load, add, subtract, one shift-add
// multiply step or one restoring divide step per cycle.
// ----------------------------------------------------------------------------
module fbp_step_unit import fbp_pkg::*; (
    input  logic              i_clk,
    input  t_unit_ctl         i_ctl,
    input  logic [ADDR_W-1:0] i_opa,
    input  logic [ADDR_W-1:0] i_opb,
    output logic [ADDR_W-1:0] o_acc,
    output logic [SLOT_W-1:0] o_quot
);

    logic [ADDR_W-1:0] r_acc;
    logic [ADDR_W-1:0] n_acc;
    logic [SLOT_W-1:0] r_quot;
    logic [SLOT_W-1:0] n_quot;
    logic [ADDR_W-1:0] shifted;
    logic [ADDR_W-1:0] add_x;
    logic [ADDR_W-1:0] add_y;
    logic              add_sub;
    logic [ADDR_W:0]   sum;

    assign shifted = i_opb << i_ctl.shift;

    // single adder; carry out of a subtract means no borrow
    assign sum = {1'b0, add_x} + {1'b0, add_y ^ {ADDR_W{add_sub}}} + (ADDR_W + 1)'(add_sub);

    always_comb begin
        add_x   = r_acc;
        add_y   = '0;
        add_sub = 1'b0;
        n_acc   = r_acc;
        n_quot  = r_quot;
        unique case (i_ctl.op)
            U_HOLD: begin
            end
            U_LOAD: begin
                n_acc = i_opa;
            end
            U_ADD: begin
                add_y = i_opb;
                n_acc = sum[ADDR_W-1:0];
            end
            U_SUB: begin
                add_x   = i_opa;
                add_y   = i_opb;
                add_sub = 1'b1;
                n_acc   = sum[ADDR_W-1:0];
            end
            U_MUL: begin
                add_y = i_ctl.mbit ? shifted : '0;
                n_acc = sum[ADDR_W-1:0];
            end
            U_DIV: begin
                add_y   = shifted;
                add_sub = 1'b1;
                n_quot  = {r_quot[SLOT_W-2:0], sum[ADDR_W]};
                if (sum[ADDR_W]) begin
                    n_acc = sum[ADDR_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_quot <= n_quot;
    end

    assign o_acc  = r_acc;
    assign o_quot = r_quot;

endmodule

FILE: tb/pool_reply_checker.sv
// ----------------------------------------------------------------------------
// pool_reply_checker
// Watches the config port and both channels of the block pool free list. It
// keeps its own copy of the registers and the free list, works out the reply
// to each accepted command word, and compares the reply words in order.
// ----------------------------------------------------------------------------
module pool_reply_checker import fbp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [OP_W-1:0]      i_opcode,
    input  logic [ADDR_W-1:0]    i_address,
    input  logic [SIZE_W-1:0]    i_request_size,
    input  logic [ALIGN_W-1:0]   i_request_align,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [ADDR_W-1:0]    i_slot_address,
    input  logic [STAT_W-1:0]    i_status,
    input  logic [CNT_W-1:0]     i_free_slots,
    output int                   o_pending,
    output int                   o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [ADDR_W-1:0] slot_address;
        t_status           status;
        logic [CNT_W-1:0]  free_slots;
    } t_pool_reply;

    logic [ADDR_W-1:0]  cfg_base;
    logic [SIZE_W-1:0]  cfg_size;
    logic [ALIGN_W-1:0] cfg_align;
    logic [CNT_W-1:0]   cfg_count;

    logic [SLOT_W-1:0]  link_idx [POOL_DEPTH];
    bit                 link_ok  [POOL_DEPTH];
    logic [SLOT_W-1:0]  head_idx;
    bit                 head_ok;
    logic [CNT_W-1:0]   free_cnt;

    t_pool_reply        awaited_replies [$];
    int                 err_count;

    function automatic int unsigned eff_size();
        return (cfg_size < 8) ? 8 : cfg_size;
    endfunction

    // round up to a power of two, clamped to 8..8192
    function automatic longint unsigned eff_align();
        longint unsigned want;
        longint unsigned p;
        want = (cfg_align < 8) ? 8 : cfg_align;
        p = 8;
        while (p < want && p < 8192) p <<= 1;
        return p;
    endfunction

    function automatic int unsigned slots_in_use();
        return (cfg_count > POOL_DEPTH) ? POOL_DEPTH : cfg_count;
    endfunction

    function automatic void rebuild_free_list();
        int unsigned n;
        n = slots_in_use();
        for (int i = 0; i < POOL_DEPTH; i++) begin
            link_idx[i] = '0;
            link_ok[i]  = 1'b0;
        end
        for (int unsigned i = 0; i + 1 < n; i++) begin
            link_idx[i] = SLOT_W'(i + 1);
            link_ok[i]  = 1'b1;
        end
        head_idx = '0;
        head_ok  = (n != 0);
        free_cnt = CNT_W'(n);
    endfunction

    function automatic t_pool_reply predict_reply(input t_opcode op,
                                                  input logic [ADDR_W-1:0] addr,
                                                  input logic [SIZE_W-1:0] rsize,
                                                  input logic [ALIGN_W-1:0] ralign);
        t_pool_reply     r;
        longint unsigned ea;
        longint unsigned stride;
        longint unsigned first;
        longint unsigned off;
        int unsigned     n;
        int unsigned     s;
        ea     = eff_align();
        stride = (eff_size() + ea - 1) & ~(ea - 1);
        first  = ({32'd0, cfg_base} + ea - 1) & ~(ea - 1) & 64'hFFFF_FFFF;
        n      = slots_in_use();
        r.slot_address = '0;
        r.status       = STAT_OK;
        case (op)
            OP_ALLOC: begin
                if (rsize > eff_size()) begin
                    r.status = STAT_SIZE;
                end else if (ralign > ea) begin
                    r.status = STAT_ALIGN;
                end else if (!head_ok) begin
                    r.status = STAT_OOM;
                end else begin
                    s = head_idx;
                    r.slot_address = ADDR_W'(first + s * stride);
                    head_idx = link_idx[s];
                    head_ok  = link_ok[s];
                    if (free_cnt != 0) free_cnt--;
                end
            end
            OP_RELEASE: begin
                if (addr != '0) begin
                    // offset wraps modulo 2^32 below the first slot
                    off = ({32'd0, addr} - first) & 64'hFFFF_FFFF;
                    if (n == 0 || off > (n - 1) * stride) begin
                        r.status = STAT_BOUNDS;
                    end else if (off % stride != 0) begin
                        r.status = STAT_MISALIGN;
                    end else begin
                        s = 32'((off / stride) % POOL_DEPTH);
                        link_idx[s] = head_idx;
                        link_ok[s]  = head_ok;
                        head_idx    = SLOT_W'(s);
                        head_ok     = 1'b1;
                        if (free_cnt < FREE_MAX) free_cnt++;
                    end
                end
            end
            OP_RESET: rebuild_free_list();
            default: ;
        endcase
        r.free_slots = free_cnt;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_pool_reply want;
        if (!i_rst_n) begin
            cfg_base  = '0;
            cfg_size  = SIZE_W'(SIZE_RESET);
            cfg_align = ALIGN_W'(ALIGN_RESET);
            cfg_count = CNT_W'(SLOT_COUNT_RESET);
            rebuild_free_list();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (awaited_replies.size() == 0) begin
                    $error("reply word with none outstanding: slot_address %h status %0d free %0d",
                           i_slot_address, i_status, i_free_slots);
                    err_count++;
                end else begin
                    want = awaited_replies.pop_front();
                    if (i_slot_address !== want.slot_address) begin
                        $error("slot_address: expected %h, got %h",
                               want.slot_address, i_slot_address);
                        err_count++;
                    end
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_status);
                        err_count++;
                    end
                    if (i_free_slots !== want.free_slots) begin
                        $error("free_slots: expected %0d, got %0d",
                               want.free_slots, i_free_slots);
                        err_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_BASE:  cfg_base  = i_cfg_data[ADDR_W-1:0];
                    CFG_SIZE:  cfg_size  = i_cfg_data[SIZE_W-1:0];
                    CFG_ALIGN: cfg_align = i_cfg_data[ALIGN_W-1:0];
                    CFG_COUNT: cfg_count = i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                awaited_replies.push_back(predict_reply(t_opcode'(i_opcode), i_address,
                                                        i_request_size, i_request_align));
            end
        end
        o_pending <= awaited_replies.size();
        o_errors  <= err_count;
    end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the block pool free list: a directed pass over the error and
// edge cases, then random allocate/release traffic under several register
// settings, with random idling on both channels and long output hold-offs.
// ----------------------------------------------------------------------------
module tb import fbp_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [OP_W-1:0]      i_opcode;
    logic [ADDR_W-1:0]    i_address;
    logic [SIZE_W-1:0]    i_request_size;
    logic [ALIGN_W-1:0]   i_request_align;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [ADDR_W-1:0]    o_slot_address;
    logic [STAT_W-1:0]    o_status;
    logic [CNT_W-1:0]     o_free_slots;

    int pending_count;
    int fail_count;
    bit calm;
    bit hold_out;

    // register copy used only to aim addresses at real slots and requests at legal sizes and alignments
    logic [ADDR_W-1:0]  cur_base;
    logic [SIZE_W-1:0]  cur_size;
    logic [ALIGN_W-1:0] cur_align;
    logic [CNT_W-1:0]   cur_count;

    fixed_block_pool_free_list u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_opcode        (i_opcode),
        .i_address       (i_address),
        .i_request_size  (i_request_size),
        .i_request_align (i_request_align),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_slot_address  (o_slot_address),
        .o_status        (o_status),
        .o_free_slots    (o_free_slots)
    );

    pool_reply_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_opcode        (i_opcode),
        .i_address       (i_address),
        .i_request_size  (i_request_size),
        .i_request_align (i_request_align),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_slot_address  (o_slot_address),
        .i_status        (o_status),
        .i_free_slots    (o_free_slots),
        .o_pending       (pending_count),
        .o_errors        (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // receiver: random stalls, or a long hold-off when asked
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_out) begin
                i_out_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
                hold_out = 1'b0;
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= !calm && ($urandom_range(99) < 21);
            end
        end
    end

    function automatic int unsigned pool_size();
        return (cur_size < 8) ? 8 : cur_size;
    endfunction

    function automatic longint unsigned pool_align();
        longint unsigned want;
        longint unsigned p;
        want = (cur_align < 8) ? 8 : cur_align;
        p = 8;
        while (p < want && p < 8192) p <<= 1;
        return p;
    endfunction

    function automatic longint unsigned pool_stride();
        return (pool_size() + pool_align() - 1) & ~(pool_align() - 1);
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(input longint unsigned k);
        longint unsigned first;
        first = ({32'd0, cur_base} + pool_align() - 1) & ~(pool_align() - 1);
        return ADDR_W'(first + k * pool_stride());
    endfunction

    task automatic send_word(input t_opcode op, input logic [ADDR_W-1:0] addr,
                             input logic [SIZE_W-1:0] rsize,
                             input logic [ALIGN_W-1:0] ralign);
        if (!calm && $urandom_range(99) < 21) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_opcode        <= op;
        i_address       <= addr;
        i_request_size  <= rsize;
        i_request_align <= ralign;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // drop valid and hold until every reply is back
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_random_op(input bit push_heavy);
        int unsigned        pick;
        int unsigned        n;
        int unsigned        k;
        longint unsigned    cap;
        logic [ADDR_W-1:0]  junk_addr;
        logic [SIZE_W-1:0]  junk_size;
        logic [ALIGN_W-1:0] junk_align;
        n          = (cur_count > POOL_DEPTH) ? POOL_DEPTH : cur_count;
        k          = (n == 0) ? 0 : $urandom_range(n - 1);
        cap        = (pool_align() > 4096) ? 4096 : pool_align();
        junk_addr  = $urandom;
        junk_size  = SIZE_W'($urandom);
        junk_align = ALIGN_W'($urandom_range(4096));
        pick       = $urandom_range(99);
        if (push_heavy && $urandom_range(99) < 85) pick = 50;
        if (pick < 38)
            send_word(OP_ALLOC, junk_addr, SIZE_W'($urandom_range(pool_size())),
                      ALIGN_W'($urandom_range(32'(cap))));
        else if (pick < 43)
            send_word(OP_ALLOC, junk_addr, junk_size, junk_align);
        else if (pick < 75)
            send_word(OP_RELEASE, slot_addr(k), junk_size, junk_align);
        else if (pick < 80)
            send_word(OP_RELEASE, '0, junk_size, junk_align);
        else if (pick < 86)
            send_word(OP_RELEASE, slot_addr(k) + $urandom_range(32'(pool_stride() - 1), 1),
                      junk_size, junk_align);
        else if (pick < 88)
            send_word(OP_RELEASE, slot_addr(n + $urandom_range(3)), junk_size, junk_align);
        else if (pick < 90)
            send_word(OP_RELEASE, slot_addr(0) - $urandom_range(64, 1), junk_size, junk_align);
        else if (pick < 93)
            send_word(OP_RELEASE, junk_addr, junk_size, junk_align);
        else if (pick < 96)
            send_word(OP_RESET, junk_addr, junk_size, junk_align);
        else
            send_word(OP_NONE, junk_addr, junk_size, junk_align);
    endtask

    task automatic run_phase(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] size,
                             input logic [ALIGN_W-1:0] align, input logic [CNT_W-1:0] count,
                             input int items, input bit push_heavy, input bit quiet,
                             input bit with_hold, input bit with_drain);
        wait_idle();
        // write all four registers on consecutive edges, we held high
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_BASE;
        i_cfg_data  <= CFG_W'(base);
        @(posedge i_clk);
        i_cfg_index <= CFG_SIZE;
        i_cfg_data  <= CFG_W'(size);
        @(posedge i_clk);
        i_cfg_index <= CFG_ALIGN;
        i_cfg_data  <= CFG_W'(align);
        @(posedge i_clk);
        i_cfg_index <= CFG_COUNT;
        i_cfg_data  <= CFG_W'(count);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_base  = base;
        cur_size  = size;
        cur_align = align;
        cur_count = count;
        repeat (2) @(posedge i_clk);
        calm = quiet;
        for (int i = 0; i < items; i++) begin
            if (with_hold && i == items / 3) hold_out = 1'b1;
            if (with_drain && i == items / 2) wait_idle();
            send_random_op(push_heavy);
        end
        calm = 1'b0;
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= CFG_BASE;
        i_cfg_data      <= '0;
        i_in_valid      <= 1'b0;
        i_opcode        <= OP_ALLOC;
        i_address       <= '0;
        i_request_size  <= '0;
        i_request_align <= '0;
        cur_base  = '0;
        cur_size  = SIZE_W'(SIZE_RESET);
        cur_align = ALIGN_W'(ALIGN_RESET);
        cur_count = CNT_W'(SLOT_COUNT_RESET);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset register values: 8-byte slots from address zero
        send_word(OP_ALLOC, $urandom, 16'd0, 13'd0);
        send_word(OP_ALLOC, $urandom, 16'd8, 13'd8);
        send_word(OP_ALLOC, '1, 16'd9, 13'd0);
        // size error wins over align error
        send_word(OP_ALLOC, '0, 16'hFFFF, 13'd4096);
        send_word(OP_ALLOC, $urandom, 16'd8, 13'd9);
        send_word(OP_ALLOC, $urandom, 16'd0, 13'd4096);
        send_word(OP_RELEASE, '0, '1, 13'd4096);
        send_word(OP_RELEASE, slot_addr(1), SIZE_W'($urandom),
                  ALIGN_W'($urandom_range(4096)));
        send_word(OP_RELEASE, slot_addr(1) + 4, SIZE_W'($urandom),
                  ALIGN_W'($urandom_range(4096)));
        send_word(OP_RELEASE, slot_addr(256), SIZE_W'($urandom),
                  ALIGN_W'($urandom_range(4096)));
        send_word(OP_RELEASE, slot_addr(255), SIZE_W'($urandom),
                  ALIGN_W'($urandom_range(4096)));
        send_word(OP_RELEASE, '1, SIZE_W'($urandom), ALIGN_W'($urandom_range(4096)));
        send_word(OP_RELEASE, slot_addr(1), SIZE_W'($urandom),
                  ALIGN_W'($urandom_range(4096)));
        send_word(OP_NONE, '1, '1, 13'd4096);
        send_word(OP_RESET, $urandom, SIZE_W'($urandom), ALIGN_W'($urandom_range(4096)));

        run_phase(32'h1000_0003, 16'd24,    13'd16,   9'd16,  230, 1'b0, 1'b0, 1'b0, 1'b0);
        // widest slots from the top of the address space: addresses wrap
        run_phase(32'hFFFF_FFFF, 16'hFFFF,  13'd4096, 9'd256, 230, 1'b0, 1'b0, 1'b1, 1'b0);
        run_phase(32'h0000_0000, 16'd5,     13'd3,    9'd4,   230, 1'b0, 1'b1, 1'b0, 1'b0);
        run_phase(32'h8000_0000, 16'd100,   13'd100,  9'd1,   230, 1'b0, 1'b0, 1'b0, 1'b0);
        // mostly releases: drive the free count into saturation
        run_phase(32'hFFFF_FF00, 16'd8,     13'd8,    9'd256, 400, 1'b1, 1'b0, 1'b1, 1'b1);
        run_phase(32'h1234_5678, 16'd40,    13'd8191, 9'd511, 230, 1'b0, 1'b0, 1'b0, 1'b0);
        run_phase(32'hFFFF_FFFF, 16'd8,     13'd8,    9'd0,   120, 1'b0, 1'b0, 1'b0, 1'b0);
        run_phase(32'hDEAD_BEEF, 16'd1000,  13'd64,   9'd9,   230, 1'b0, 1'b0, 1'b0, 1'b1);

        wait_idle();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
